// ===== design/sip_pkg.sv =====
package sip_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    REL_NONE      = 2'd0,
    REL_INTERSECT = 2'd1,
    REL_CONTAIN   = 2'd2
  } rel_t;

  // Classified request passed from the front end to the divider:
  // relation, hit, A start x/y, direction signs, |A dx|, |A dy|, t numerator, denominator.
  function automatic int item_bits(input int coord_bits);
    return 8 * coord_bits + 9;
  endfunction

endpackage

// ===== design/sip_if.sv =====
interface sip_in_if #(
  parameter int CoordBits = sip_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] a_start_x;
  logic signed [CoordBits-1:0] a_start_y;
  logic signed [CoordBits-1:0] a_end_x;
  logic signed [CoordBits-1:0] a_end_y;
  logic signed [CoordBits-1:0] b_start_x;
  logic signed [CoordBits-1:0] b_start_y;
  logic signed [CoordBits-1:0] b_end_x;
  logic signed [CoordBits-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sip_out_if #(
  parameter int CoordBits = sip_pkg::COORD_BITS_DEF,
  parameter int FracBits  = sip_pkg::FRAC_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           relation;
  logic                                 point_valid;
  logic signed [CoordBits+FracBits-1:0] cross_x;
  logic signed [CoordBits+FracBits-1:0] cross_y;

  modport source (
    output valid, relation, point_valid, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, relation, point_valid, cross_x, cross_y,
    output ready
  );
endinterface

// ===== design/sip_front.sv =====
module sip_front #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  sip_in_if.sink                                     in_req,
  output logic                                       q_valid,
  input  logic                                       q_ready,
  output logic [sip_pkg::item_bits(COORD_BITS)-1:0] q_item
);
  import sip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DX = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int DW = 2 * C + 3;
  localparam int MW = 2 * C + 2;

  logic en;
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r;

  logic signed [DX-1:0] adx0_r, ady0_r, bdx0_r, bdy0_r, ox0_r, oy0_r;
  logic signed [C-1:0]  ax0_r, ay0_r;
  logic                 cont0_r, betw0_r;

  logic signed [PW-1:0] pd0_r, pd1_r, pt0_r, pt1_r, ps0_r, ps1_r;
  logic signed [DX-1:0] adx1_r, ady1_r;
  logic signed [C-1:0]  ax1_r, ay1_r;
  logic                 cont1_r, betw1_r;

  logic signed [DW-1:0] den2_r, tn2_r, sn2_r;
  logic signed [DX-1:0] adx2_r, ady2_r;
  logic signed [C-1:0]  ax2_r, ay2_r;
  logic                 cont2_r, betw2_r;

  logic [sip_pkg::item_bits(COORD_BITS)-1:0] item_r;

  logic                 den_pos, den_zero, hit;
  rel_t                 rel;
  logic signed [DW-1:0] tn_mag, den_mag;
  logic signed [DX-1:0] adx_neg, ady_neg;
  logic [C-1:0]         ma, mb;
  logic [MW-1:0]        num_o, den_o;

  assign en           = !s3_v_r || q_ready;
  assign in_req.ready = en;
  assign q_valid      = s3_v_r;
  assign q_item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_req.valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx0_r  <= DX'(in_req.a_end_x) - DX'(in_req.a_start_x);
      ady0_r  <= DX'(in_req.a_end_y) - DX'(in_req.a_start_y);
      bdx0_r  <= DX'(in_req.b_end_x) - DX'(in_req.b_start_x);
      bdy0_r  <= DX'(in_req.b_end_y) - DX'(in_req.b_start_y);
      ox0_r   <= DX'(in_req.a_start_x) - DX'(in_req.b_start_x);
      oy0_r   <= DX'(in_req.a_start_y) - DX'(in_req.b_start_y);
      ax0_r   <= in_req.a_start_x;
      ay0_r   <= in_req.a_start_y;
      cont0_r <= (in_req.a_start_x <= in_req.b_start_x) &&
                 (in_req.a_start_y <= in_req.b_start_y) &&
                 (in_req.a_end_x >= in_req.b_end_x) &&
                 (in_req.a_end_y >= in_req.b_end_y);
      betw0_r <= (in_req.a_start_x <= in_req.b_start_x) &&
                 (in_req.b_start_x <= in_req.a_end_x);

      pd0_r   <= PW'(bdy0_r) * PW'(adx0_r);
      pd1_r   <= PW'(bdx0_r) * PW'(ady0_r);
      pt0_r   <= PW'(bdx0_r) * PW'(oy0_r);
      pt1_r   <= PW'(bdy0_r) * PW'(ox0_r);
      ps0_r   <= PW'(adx0_r) * PW'(oy0_r);
      ps1_r   <= PW'(ady0_r) * PW'(ox0_r);
      adx1_r  <= adx0_r;
      ady1_r  <= ady0_r;
      ax1_r   <= ax0_r;
      ay1_r   <= ay0_r;
      cont1_r <= cont0_r;
      betw1_r <= betw0_r;

      den2_r  <= DW'(pd0_r) - DW'(pd1_r);
      tn2_r   <= DW'(pt0_r) - DW'(pt1_r);
      sn2_r   <= DW'(ps0_r) - DW'(ps1_r);
      adx2_r  <= adx1_r;
      ady2_r  <= ady1_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      cont2_r <= cont1_r;
      betw2_r <= betw1_r;

      item_r  <= {rel, hit, ax2_r, ay2_r, adx2_r[DX-1], ady2_r[DX-1], ma, mb, num_o, den_o};
    end
  end

  // With a negative denominator the range tests are mirrored instead of negating first.
  always_comb begin
    den_pos  = !den2_r[DW-1];
    den_zero = (den2_r == '0);
    if (den_pos) begin
      hit = !tn2_r[DW-1] && (tn2_r <= den2_r) && !sn2_r[DW-1] && (sn2_r <= den2_r);
    end else begin
      hit = (tn2_r[DW-1] || tn2_r == '0) && (tn2_r >= den2_r) &&
            (sn2_r[DW-1] || sn2_r == '0) && (sn2_r >= den2_r);
    end
    hit = hit && !den_zero;

    priority if (!den_zero) begin
      rel = hit ? REL_INTERSECT : REL_NONE;
    end else if (cont2_r) begin
      rel = REL_CONTAIN;
    end else if (betw2_r) begin
      rel = REL_INTERSECT;
    end else begin
      rel = REL_NONE;
    end

    tn_mag  = den_pos ? tn2_r : -tn2_r;
    den_mag = den_pos ? den2_r : -den2_r;
    adx_neg = -adx2_r;
    ady_neg = -ady2_r;
    ma      = adx2_r[DX-1] ? adx_neg[C-1:0] : adx2_r[C-1:0];
    mb      = ady2_r[DX-1] ? ady_neg[C-1:0] : ady2_r[C-1:0];
    // A miss still travels through the divider, so give it a harmless ratio.
    num_o   = hit ? tn_mag[MW-1:0] : '0;
    den_o   = hit ? den_mag[MW-1:0] : MW'(1);
  end

endmodule

// ===== design/sip_queue.sv =====
module sip_queue #(
  parameter int W     = 8,
  parameter int DEPTH = sip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import sip_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign in_ready  = (cnt_r != CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/sip_back.sv =====
module sip_back #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_valid,
  output logic                                      q_ready,
  input  logic [sip_pkg::item_bits(COORD_BITS)-1:0] q_item,
  sip_out_if.source                                 out_res
);
  import sip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = 2 * C + 2;
  localparam int RW = MW + 1;
  localparam int QW = C + F;
  localparam int NS = C + F;
  localparam int VW = C + F + 2;

  typedef struct packed {
    logic [1:0]          rel;
    logic                hit;
    logic signed [C-1:0] ax;
    logic signed [C-1:0] ay;
    logic                nx;
    logic                ny;
    logic [C-1:0]        ma;
    logic [C-1:0]        mb;
    logic [MW-1:0]       num;
    logic [MW-1:0]       den;
    logic [QW-1:0]       qx;
    logic [QW-1:0]       qy;
    logic [RW-1:0]       rx;
    logic [RW-1:0]       ry;
  } stage_t;

  // One step of the shift-and-subtract multiply-divide: q:r tracks a*b*2^k / c.
  function automatic logic [QW+RW-1:0] step(
    input logic [QW-1:0] q,
    input logic [RW-1:0] r,
    input logic          abit,
    input logic [MW-1:0] b,
    input logic [MW-1:0] c
  );
    logic [RW-1:0] rr;
    logic [QW-1:0] qq;
    qq = q << 1;
    rr = r << 1;
    if (rr >= RW'(c)) begin
      rr = rr - RW'(c);
      qq = qq + QW'(1);
    end
    if (abit) begin
      rr = rr + RW'(b);
      if (rr >= RW'(c)) begin
        rr = rr - RW'(c);
        qq = qq + QW'(1);
      end
    end
    return {qq, rr};
  endfunction

  function automatic stage_t stage_step(input stage_t s, input logic abx, input logic aby);
    stage_t n;
    n = s;
    {n.qx, n.rx} = step(s.qx, s.rx, abx, s.num, s.den);
    {n.qy, n.ry} = step(s.qy, s.ry, aby, s.num, s.den);
    return n;
  endfunction

  // Adds the scaled start and rounds the whole value toward zero.
  function automatic logic [QW-1:0] finish(
    input logic signed [C-1:0] start,
    input logic                neg,
    input logic [QW-1:0]       q,
    input logic                rem_nz
  );
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] v;
    base = VW'(start) <<< F;
    v    = neg ? base - $signed(VW'(q)) : base + $signed(VW'(q));
    if (rem_nz && !neg && v[VW-1]) begin
      v = v + VW'(1);
    end else if (rem_nz && neg && !v[VW-1] && v != '0) begin
      v = v - VW'(1);
    end
    return v[QW-1:0];
  endfunction

  stage_t    st_r [NS+1];
  stage_t    nxt  [NS];
  stage_t    ld;
  stage_t    last;
  logic [NS:0] v_r;
  logic      en;

  logic              out_v_r;
  logic [1:0]        out_rel_r;
  logic              out_pv_r;
  logic [QW-1:0]     out_x_r, out_y_r;

  assign en      = !out_v_r || out_res.ready;
  assign q_ready = en;
  assign last    = st_r[NS];

  always_comb begin
    ld = '0;
    {ld.rel, ld.hit, ld.ax, ld.ay, ld.nx, ld.ny, ld.ma, ld.mb, ld.num, ld.den} = q_item;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k < C) begin : g_int
      assign nxt[k] = stage_step(st_r[k], st_r[k].ma[C-1-k], st_r[k].mb[C-1-k]);
    end else begin : g_frac
      assign nxt[k] = stage_step(st_r[k], 1'b0, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[NS-1:0], q_valid};
      out_v_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= ld;
      for (int k = 0; k < NS; k++) begin
        st_r[k+1] <= nxt[k];
      end
      out_rel_r <= last.rel;
      out_pv_r  <= last.hit;
      out_x_r   <= last.hit ? finish(last.ax, last.nx, last.qx, last.rx != '0) : '0;
      out_y_r   <= last.hit ? finish(last.ay, last.ny, last.qy, last.ry != '0) : '0;
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.relation    = out_rel_r;
  assign out_res.point_valid = out_pv_r;
  assign out_res.cross_x     = out_x_r;
  assign out_res.cross_y     = out_y_r;

`ifndef SYNTHESIS
  a_hit_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && st_r[0].hit |-> st_r[0].num <= st_r[0].den && st_r[0].den != '0)
    else $error("crossing parameter outside the unit range");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] |-> last.rx < RW'(last.den) && last.ry < RW'(last.den))
    else $error("divider remainder not below the denominator");
  a_pv_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_pv_r |-> out_rel_r == REL_INTERSECT)
    else $error("crossing point given without an intersect relation");
  a_pv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_pv_r |-> out_x_r == '0 && out_y_r == '0)
    else $error("point fields not cleared for a result without a point");
`endif

endmodule

// ===== design/segment_intersection_point.sv =====
// Segment pair intersection. Each request carries two segments A and B with signed
// integer endpoints; each result gives their relation (none, intersect, A contains B)
// and, on a proper crossing, the point A start + t * (A end - A start) in fixed point
// with FRAC_BITS fraction bits, rounded toward zero; the point fields read zero when
// point_valid is low. One request is accepted per clock while no stall backs up from the
// result side. A four-stage front end forms the cross products and classifies the pair,
// a small queue follows, and a pipelined shift-and-subtract multiply-divide of
// COORD_BITS + FRAC_BITS stages with an output register produces the point.
module segment_intersection_point #(
  parameter int COORD_BITS  = sip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = sip_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = sip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sip_in_if.sink    in_req,
  sip_out_if.source out_res
);
  import sip_pkg::*;

  localparam int IW = item_bits(COORD_BITS);

  logic          fq_valid, fq_ready;
  logic [IW-1:0] fq_item;
  logic          qb_valid, qb_ready;
  logic [IW-1:0] qb_item;

  sip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  sip_queue #(
    .W    (IW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_data  (fq_item),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_data (qb_item)
  );

  sip_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(qb_valid),
    .q_ready(qb_ready),
    .q_item (qb_item),
    .out_res(out_res)
  );

endmodule

// ===== sim/segment_intersection_point_tb.sv =====
module segment_intersection_point_tb;
  import sip_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int PW = CB + FB;
  localparam int LATENCY = CB + FB + 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct packed {
    rel_t            rel;
    logic            pv;
    logic [PW-1:0]   px;
    logic [PW-1:0]   py;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sip_in_if  #(.CoordBits(CB)) in_req ();
  sip_out_if #(.CoordBits(CB), .FracBits(FB)) out_res ();

  segment_intersection_point uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  crossing_t expected_crossings[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int hits = 0;
  int contains = 0;
  int cycles = 0;
  logic stall_on = 1'b0;

  // Point coordinate: start + (tn/den)*d in fixed point, truncated toward zero.
  function automatic logic [PW-1:0] point_coord(longint start, longint d, longint tn,
                                                 longint den);
    longint num;
    longint q;
    longint v;
    num = d * tn * (longint'(1) << FB);
    q = num / den;
    v = start * (longint'(1) << FB) + q;
    // Truncating the sum as a whole: correct when the parts have opposite signs.
    if (num % den != 0) begin
      if (num > 0 && v < 0) v = v + 1;
      else if (num < 0 && v > 0) v = v - 1;
    end
    return v[PW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    crossing_t r;
    longint adx, ady, bdx, bdy, ox, oy, den, tn, sn;
    r = '{rel: REL_NONE, pv: 1'b0, px: '0, py: '0};
    adx = longint'(s.ax2) - s.ax1;
    ady = longint'(s.ay2) - s.ay1;
    bdx = longint'(s.bx2) - s.bx1;
    bdy = longint'(s.by2) - s.by1;
    ox = longint'(s.ax1) - s.bx1;
    oy = longint'(s.ay1) - s.by1;
    den = bdy * adx - bdx * ady;
    if (den == 0) begin
      if (s.ax1 <= s.bx1 && s.ay1 <= s.by1 && s.ax2 >= s.bx2 && s.ay2 >= s.by2)
        r.rel = REL_CONTAIN;
      else if (s.ax1 <= s.bx1 && s.bx1 <= s.ax2)
        r.rel = REL_INTERSECT;
    end else begin
      tn = bdx * oy - bdy * ox;
      sn = adx * oy - ady * ox;
      if (den < 0) begin
        den = -den;
        tn = -tn;
        sn = -sn;
      end
      if (tn >= 0 && tn <= den && sn >= 0 && sn <= den) begin
        r.rel = REL_INTERSECT;
        r.pv = 1'b1;
        r.px = point_coord(s.ax1, adx, tn, den);
        r.py = point_coord(s.ay1, ady, tn, den);
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", received, what, got, want);
  endtask

  initial begin
    in_req.valid = 1'b0;
    {in_req.a_start_x, in_req.a_start_y, in_req.a_end_x, in_req.a_end_y} = '0;
    {in_req.b_start_x, in_req.b_start_y, in_req.b_end_x, in_req.b_end_y} = '0;
    out_res.ready = 1'b0;
  end

  // Receiver stalls in runs, with long ready stretches in between.
  always @(negedge clk) begin
    if (stall_on) out_res.ready <= ($urandom_range(0, 3) != 0);
    else out_res.ready <= 1'b1;
  end

  always @(posedge clk) begin
    crossing_t want;
    cycles++;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_crossings.size() == 0) begin
        report("unexpected result, relation", out_res.relation, '0);
      end else begin
        want = expected_crossings.pop_front();
        if (out_res.relation !== want.rel) report("relation", out_res.relation, want.rel);
        if (out_res.point_valid !== want.pv)
          report("point_valid", out_res.point_valid, want.pv);
        if (out_res.cross_x !== want.px) report("cross_x", out_res.cross_x, want.px);
        if (out_res.cross_y !== want.py) report("cross_y", out_res.cross_y, want.py);
      end
      received++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_pair(seg_pair_t s);
    crossing_t c;
    in_req.valid <= 1'b1;
    in_req.a_start_x <= s.ax1;
    in_req.a_start_y <= s.ay1;
    in_req.a_end_x <= s.ax2;
    in_req.a_end_y <= s.ay2;
    in_req.b_start_x <= s.bx1;
    in_req.b_start_y <= s.by1;
    in_req.b_end_x <= s.bx2;
    in_req.b_end_y <= s.by2;
    do @(posedge clk); while (!in_req.ready);
    c = predict_crossing(s);
    expected_crossings.push_back(c);
    sent++;
    if (c.pv) hits++;
    if (c.rel == REL_CONTAIN) contains++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_req.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 40) - 20);
      default: return coord_t'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = coord_t'(16'h7fff);
    mn = coord_t'(16'h8000);
    // Plain crossing, endpoint touches (t and s at 0 and 1), misses.
    send_pair('{0, 0, 10, 10, 0, 10, 10, 0});
    send_pair('{0, 0, 10, 0, 0, 0, 0, 10});
    send_pair('{0, 0, 10, 0, 10, 0, 10, 10});
    send_pair('{0, 0, 10, 0, 5, -5, 5, 0});
    send_pair('{0, 0, 10, 0, 11, -5, 11, 5});
    send_pair('{0, 0, 10, 0, 5, 1, 5, 5});
    // Fractional points with negative directions.
    send_pair('{3, 7, -4, -2, -1, 5, 2, -6});
    send_pair('{0, 0, -3, 0, -1, -1, -2, 2});
    send_pair('{-1, -1, 2, 1, 0, 3, 1, -3});
    // Parallel and degenerate cases: contain, intersect, none.
    send_pair('{0, 0, 10, 10, 2, 2, 5, 5});
    send_pair('{0, 0, 10, 0, 5, 3, 20, 3});
    send_pair('{0, 0, 10, 0, -5, 3, 20, 3});
    send_pair('{4, 4, 4, 4, 4, 4, 4, 4});
    send_pair('{0, 0, 10, 10, 10, 12, 20, 22});
    // Extremes of the coordinate range.
    send_pair('{mn, mn, mx, mx, mn, mx, mx, mn});
    send_pair('{mx, mn, mn, mx, mn, mn, mx, mx});
    send_pair('{mn, 0, mx, 0, 0, mn, 0, mx});
    send_pair('{mx, mx, mn, mn, mx, mx, mx, mx});
    send_pair('{mn, mn, mn, mn, mx, mx, mx, mx});
    send_pair('{mx, mx, mx, mx, mx, mx, mx, mx});
    send_pair('{-1, -1, -1, -1, 0, 0, 0, 0});
    idle_gap(1);
  endtask

  task automatic test_random(int count);
    seg_pair_t s;
    int burst;
    int mode;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
          // Parallel pair: B is A shifted by a small offset (mode 0 replaces it with random bits).
          s.ax1 = rand_coord(mode); s.ay1 = rand_coord(mode);
          s.ax2 = rand_coord(mode); s.ay2 = rand_coord(mode);
          s.bx1 = s.ax1 + coord_t'($urandom_range(0, 6) - 3);
          s.by1 = s.ay1 + coord_t'($urandom_range(0, 6) - 3);
          s.bx2 = s.bx1 + (s.ax2 - s.ax1);
          s.by2 = s.by1 + (s.ay2 - s.ay1);
          if (mode == 0) s = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        end else begin
          s = '{rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        end
        send_pair(s);
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      stall_on = (n % 200) > 80;
    end
    idle_gap(1);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(600);
    while (expected_crossings.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d segment pairs, checked %0d results", sent, received);
    $display("Crossings with a point: %0d, containments: %0d", hits, contains);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
